// ===== sv/pei_pkg.sv =====
package pei_pkg;

   localparam int VAL_W     = 48;
   localparam int NODE_IN_W = 10;
   localparam int MULT_W    = 47;
   localparam int FRAC_W    = 32;

   localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   typedef enum logic [1:0] {
      OP_LOAD = 2'd0,
      OP_PAIR = 2'd1,
      OP_READ = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]               op;
      logic [NODE_IN_W-1:0]     node_a;
      logic [NODE_IN_W-1:0]     node_b;
      logic signed [VAL_W-1:0]  scalar_a;
      logic signed [VAL_W-1:0]  scalar_b;
      logic signed [VAL_W-1:0]  vec_x;
      logic signed [VAL_W-1:0]  vec_y;
      logic signed [VAL_W-1:0]  vec_z;
      logic signed [VAL_W-1:0]  accel_x;
      logic signed [VAL_W-1:0]  accel_y;
      logic signed [VAL_W-1:0]  accel_z;
   } req_type;

   typedef struct packed {
      logic [NODE_IN_W-1:0]     out_node;
      logic signed [VAL_W-1:0]  new_energy;
      logic signed [VAL_W-1:0]  energy_rate;
   } rsp_type;

   // start pulse and rounding shift select (33 instead of 32) for the multiplier
   typedef struct packed {
      logic start;
      logic half;
   } mul_cmd_type;

   function automatic logic signed [VAL_W-1:0] add_sat(input logic signed [VAL_W-1:0] a,
                                                        input logic signed [VAL_W-1:0] b);
      logic [VAL_W:0] s;
      s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
      if (s[VAL_W] != s[VAL_W-1]) begin
         add_sat = s[VAL_W] ? VAL_MIN : VAL_MAX;
      end else begin
         add_sat = s[VAL_W-1:0];
      end
   endfunction

   function automatic logic signed [VAL_W-1:0] sub_sat(input logic signed [VAL_W-1:0] a,
                                                        input logic signed [VAL_W-1:0] b);
      logic [VAL_W:0] s;
      s = {a[VAL_W-1], a} - {b[VAL_W-1], b};
      if (s[VAL_W] != s[VAL_W-1]) begin
         sub_sat = s[VAL_W] ? VAL_MIN : VAL_MAX;
      end else begin
         sub_sat = s[VAL_W-1:0];
      end
   endfunction

endpackage

// ===== sv/pei_mul.sv =====
// Shared signed 48x48 multiplier: four 24x24 partial products, one per cycle,
// then round to nearest (ties away from zero), shift by 32 or 33, saturate.
module pei_mul (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pei_pkg::mul_cmd_type                  cmd,
   input  logic signed [pei_pkg::VAL_W-1:0]      op_a,
   input  logic signed [pei_pkg::VAL_W-1:0]      op_b,
   output logic                                  done,
   output logic signed [pei_pkg::VAL_W-1:0]      result
);

   logic [47:0]  ma_ff;
   logic [47:0]  mb_ff;
   logic         neg_ff;
   logic         half_ff;
   logic [2:0]   step_ff;
   logic         busy_ff;
   logic         done_ff;
   logic [95:0]  acc_ff;
   logic signed [47:0] res_ff;

   logic [47:0]  pp;
   logic [95:0]  pp_sh;
   logic [96:0]  rnd_sum;
   logic [96:0]  shifted;
   logic [47:0]  lim;
   logic [47:0]  mag;
   logic signed [47:0] res_in;

   // form partial product and final rounding
   always_comb begin
      pp = (step_ff[1] ? ma_ff[47:24] : ma_ff[23:0]) *
           (step_ff[0] ? mb_ff[47:24] : mb_ff[23:0]);
      case (step_ff[1:0])
         2'b00:   pp_sh = {48'b0, pp};
         2'b01,
         2'b10:   pp_sh = {24'b0, pp, 24'b0};
         default: pp_sh = {pp, 48'b0};
      endcase
      rnd_sum = {1'b0, acc_ff} + (half_ff ? (97'd1 << 32) : (97'd1 << 31));
      shifted = half_ff ? (rnd_sum >> 33) : (rnd_sum >> 32);
      lim     = neg_ff ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
      mag     = (shifted > {49'b0, lim}) ? lim : shifted[47:0];
      res_in  = neg_ff ? -mag : mag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 3'd0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            ma_ff   <= op_a[47] ? -op_a : op_a;
            mb_ff   <= op_b[47] ? -op_b : op_b;
            neg_ff  <= op_a[47] != op_b[47];
            half_ff <= cmd.half;
            acc_ff  <= 96'd0;
            step_ff <= 3'd0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (step_ff == 3'd4) begin
               res_ff  <= res_in;
               done_ff <= 1'b1;
               busy_ff <= 1'b0;
            end else begin
               acc_ff  <= acc_ff + pp_sh;
               step_ff <= step_ff + 3'd1;
            end
         end
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

// ===== sv/pairwise_energy_increment_accumulator_top.sv =====
// Channel  | Ports                               | Direction | Item
// request  | req_valid, req_stall, req_payload   | in        | load / pair / read
// response | rsp_valid, rsp_stall, rsp_payload   | out       | node energy report
// config   | csr_wr_en, csr_wr_data              | in        | step multiplier
//
// One item at a time: accept it, wrap its node indexes, then run its operation.
// Load writes one vector element per dimension. Pair time is set by the
// shared multiplier (3*DIMS + 4 products, one at a time) and the
// bit-serial divider for the weight. Read takes one product.
// Reset is synchronous and clears control only; stores hold garbage until loaded.
// A finished read waits in the output register; while that response is stalled,
// the next read holds in its output step and stalls the input.
module pairwise_energy_increment_accumulator_top #(
   parameter int NODE_COUNT = 1024,
   parameter int DIMS       = 3
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  pei_pkg::req_type                  req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output pei_pkg::rsp_type                  rsp_payload,
   input  logic                              csr_wr_en,
   input  logic [pei_pkg::MULT_W-1:0]        csr_wr_data
);

   localparam int NODE_W    = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int VEC_DEPTH = NODE_COUNT * DIMS;
   localparam int VADDR_W   = (VEC_DEPTH > 1) ? $clog2(VEC_DEPTH) : 1;
   localparam int DIM_W     = (DIMS > 1) ? $clog2(DIMS) : 1;
   localparam int VW        = pei_pkg::VAL_W;
   localparam int NIW       = pei_pkg::NODE_IN_W;
   localparam int RECIP_SH  = 20;
   localparam logic [31:0] RECIP = 32'((1 << RECIP_SH) / NODE_COUNT + 1);

   typedef enum logic [4:0] {
      S_IDLE, S_REDUCE, S_LOAD,
      S_P_RD_I, S_P_MUL_I, S_P_RD_J, S_P_MUL_J, S_P_MUL_DOT, S_P_DELTA, S_P_DIV,
      S_P_MUL_TI, S_P_MUL_TJ, S_P_RD_MASS_B, S_P_MUL_AI, S_P_RD_MASS_A, S_P_MUL_BI,
      S_P_RD_RATE_A, S_P_WR_RATE_A, S_P_RD_RATE_B, S_P_WR_RATE_B,
      S_R_RD, S_R_MUL, S_R_OUT
   } state_type;

   state_type              state_ff;
   pei_pkg::req_type       item_ff;
   pei_pkg::rsp_type       rsp_ff;
   logic                   rsp_valid_ff;
   logic [NIW-1:0]         nodea_ff;
   logic [NIW-1:0]         nodeb_ff;
   logic [DIM_W-1:0]       dim_ff;
   logic                   wait_ff;
   logic [pei_pkg::MULT_W-1:0] mult_ff;
   logic signed [VW-1:0]   delta_ff;
   logic signed [VW-1:0]   vsave_ff;
   logic signed [VW-1:0]   vi_ff;
   logic signed [VW-1:0]   vij_ff;
   logic signed [VW-1:0]   ti_ff;
   logic signed [VW-1:0]   tj_ff;
   logic signed [VW-1:0]   ai_ff;
   logic signed [VW-1:0]   bi_ff;
   logic [VW:0]            div_r_ff;
   logic [VW:0]            div_d_ff;
   logic [31:0]            q_ff;
   logic [4:0]             div_cnt_ff;

   // storage
   logic signed [VW-1:0]   mass_mem   [NODE_COUNT];
   logic signed [VW-1:0]   energy_mem [NODE_COUNT];
   logic signed [VW-1:0]   rate_mem   [NODE_COUNT];
   logic signed [VW-1:0]   vel_mem    [VEC_DEPTH];
   logic signed [VW-1:0]   acc_mem    [VEC_DEPTH];
   logic signed [VW-1:0]   mass_rd_ff;
   logic signed [VW-1:0]   energy_rd_ff;
   logic signed [VW-1:0]   rate_rd_ff;
   logic signed [VW-1:0]   vel_rd_ff;
   logic signed [VW-1:0]   acc_rd_ff;

   logic [NODE_W-1:0]      na_idx;
   logic [NODE_W-1:0]      nb_idx;
   logic [NODE_W-1:0]      vnode;
   logic [VADDR_W-1:0]     vaddr;
   logic [NODE_W-1:0]      mass_addr;
   logic [NODE_W-1:0]      rate_addr;
   logic                   node_we;
   logic                   vec_we;
   logic                   rate_we;
   logic signed [VW-1:0]   rate_wdata;
   logic signed [VW-1:0]   vec_comp;
   logic signed [VW-1:0]   acc_comp;
   logic                   dim_last;
   logic [VW-1:0]          ua;
   logic [VW-1:0]          ub;
   logic [VW+1:0]          div_r2;
   logic                   div_ge;
   logic signed [VW-1:0]   wj;
   logic                   in_mul;
   pei_pkg::mul_cmd_type   mul_cmd;
   logic signed [VW-1:0]   mul_a;
   logic signed [VW-1:0]   mul_b;
   logic                   mul_done;
   logic signed [VW-1:0]   mul_res;

   // wrap a node index: quotient by reciprocal multiplication, exact for 10-bit indexes
   function automatic logic [NIW-1:0] wrap_node(input logic [NIW-1:0] n);
      logic [31:0] q;
      logic [31:0] r;
      q = ({22'b0, n} * RECIP) >> RECIP_SH;
      r = {22'b0, n} - q * 32'(NODE_COUNT);
      wrap_node = NIW'(r);
   endfunction

   pei_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .cmd    (mul_cmd),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .done   (mul_done),
      .result (mul_res)
   );

   // decode addresses, write strobes and arithmetic operands
   always_comb begin
      na_idx    = NODE_W'(nodea_ff);
      nb_idx    = NODE_W'(nodeb_ff);
      vnode     = (state_ff == S_P_RD_J || state_ff == S_P_MUL_J) ? nb_idx : na_idx;
      vaddr     = VADDR_W'(vnode) * VADDR_W'(DIMS) + VADDR_W'(dim_ff);
      mass_addr = (state_ff == S_P_RD_MASS_B) ? nb_idx : na_idx;
      rate_addr = (state_ff == S_P_RD_RATE_B || state_ff == S_P_WR_RATE_B) ? nb_idx : na_idx;
      dim_last  = dim_ff == DIM_W'(DIMS - 1);
      node_we   = (state_ff == S_LOAD) && (dim_ff == DIM_W'(0));
      vec_we    = state_ff == S_LOAD;

      if (dim_ff == DIM_W'(0)) begin
         vec_comp = item_ff.vec_x;
         acc_comp = item_ff.accel_x;
      end else if (dim_ff == DIM_W'(1)) begin
         vec_comp = item_ff.vec_y;
         acc_comp = item_ff.accel_y;
      end else begin
         vec_comp = item_ff.vec_z;
         acc_comp = item_ff.accel_z;
      end

      rate_we    = node_we || state_ff == S_P_WR_RATE_A || state_ff == S_P_WR_RATE_B;
      if (state_ff == S_P_WR_RATE_A) begin
         rate_wdata = pei_pkg::add_sat(rate_rd_ff, ai_ff);
      end else if (state_ff == S_P_WR_RATE_B) begin
         rate_wdata = pei_pkg::add_sat(rate_rd_ff, bi_ff);
      end else begin
         rate_wdata = '0;
      end

      ua      = item_ff.scalar_a[VW-1] ? -item_ff.scalar_a : item_ff.scalar_a;
      ub      = item_ff.scalar_b[VW-1] ? -item_ff.scalar_b : item_ff.scalar_b;
      div_r2  = {div_r_ff, 1'b0};
      div_ge  = div_r2 >= {1'b0, div_d_ff};
      wj      = VW'(33'h1_0000_0000 - {1'b0, q_ff});

      in_mul = 1'b1;
      mul_cmd.half = 1'b0;
      case (state_ff)
         S_P_MUL_I, S_P_MUL_J: begin
            mul_a = acc_rd_ff;
            mul_b = {1'b0, mult_ff};
            mul_cmd.half = 1'b1;
         end
         S_P_MUL_DOT: begin
            mul_a = vij_ff;
            mul_b = vec_comp;
         end
         S_P_MUL_TI: begin
            mul_a = {16'b0, q_ff};
            mul_b = delta_ff;
         end
         S_P_MUL_TJ: begin
            mul_a = wj;
            mul_b = delta_ff;
         end
         S_P_MUL_AI: begin
            mul_a = mass_rd_ff;
            mul_b = ti_ff;
         end
         S_P_MUL_BI: begin
            mul_a = mass_rd_ff;
            mul_b = tj_ff;
         end
         S_R_MUL: begin
            mul_a = rate_rd_ff;
            mul_b = {1'b0, mult_ff};
         end
         default: begin
            mul_a  = '0;
            mul_b  = '0;
            in_mul = 1'b0;
         end
      endcase
      mul_cmd.start = in_mul && !wait_ff;
   end

   // node stores: read data registered
   always_ff @(posedge clock) begin
      if (node_we) begin
         mass_mem[na_idx]   <= item_ff.scalar_a;
         energy_mem[na_idx] <= item_ff.scalar_b;
      end
      mass_rd_ff   <= mass_mem[mass_addr];
      energy_rd_ff <= energy_mem[na_idx];
   end

   always_ff @(posedge clock) begin
      if (rate_we) begin
         rate_mem[rate_addr] <= rate_wdata;
      end
      rate_rd_ff <= rate_mem[rate_addr];
   end

   // vector stores
   always_ff @(posedge clock) begin
      if (vec_we) begin
         vel_mem[vaddr] <= vec_comp;
         acc_mem[vaddr] <= acc_comp;
      end
      vel_rd_ff <= vel_mem[vaddr];
      acc_rd_ff <= acc_mem[vaddr];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         wait_ff      <= 1'b0;
         mult_ff      <= '0;
      end else begin
         if (csr_wr_en) begin
            mult_ff <= csr_wr_data;
         end
         if (rsp_valid_ff && !rsp_stall && state_ff != S_R_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         if (in_mul && !wait_ff) begin
            wait_ff <= 1'b1;
         end else if (mul_done) begin
            wait_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  item_ff    <= req_payload;
                  nodea_ff   <= req_payload.node_a;
                  nodeb_ff   <= req_payload.node_b;
                  state_ff   <= S_REDUCE;
               end
            end
            // wrap indexes into the node range
            S_REDUCE: begin
               nodea_ff <= wrap_node(nodea_ff);
               nodeb_ff <= wrap_node(nodeb_ff);
               dim_ff   <= '0;
               delta_ff <= '0;
               case (item_ff.op)
                  pei_pkg::OP_LOAD: state_ff <= S_LOAD;
                  pei_pkg::OP_PAIR: state_ff <= S_P_RD_I;
                  pei_pkg::OP_READ: state_ff <= S_R_RD;
                  default:          state_ff <= S_IDLE;
               endcase
            end
            S_LOAD: begin
               dim_ff <= dim_ff + DIM_W'(1);
               if (dim_last) begin
                  state_ff <= S_IDLE;
               end
            end
            S_P_RD_I: state_ff <= S_P_MUL_I;
            S_P_MUL_I: begin
               if (!wait_ff) begin
                  vsave_ff <= vel_rd_ff;
               end else if (mul_done) begin
                  vi_ff    <= pei_pkg::add_sat(vsave_ff, mul_res);
                  state_ff <= S_P_RD_J;
               end
            end
            S_P_RD_J: state_ff <= S_P_MUL_J;
            S_P_MUL_J: begin
               if (!wait_ff) begin
                  vsave_ff <= vel_rd_ff;
               end else if (mul_done) begin
                  vij_ff   <= pei_pkg::sub_sat(vi_ff, pei_pkg::add_sat(vsave_ff, mul_res));
                  state_ff <= S_P_MUL_DOT;
               end
            end
            S_P_MUL_DOT: begin
               if (wait_ff && mul_done) begin
                  delta_ff <= pei_pkg::add_sat(delta_ff, mul_res);
                  dim_ff   <= dim_ff + DIM_W'(1);
                  state_ff <= dim_last ? S_P_DELTA : S_P_RD_I;
               end
            end
            // remove base rates and start the weight division
            S_P_DELTA: begin
               delta_ff   <= pei_pkg::sub_sat(delta_ff,
                                pei_pkg::add_sat(item_ff.scalar_a, item_ff.scalar_b));
               div_r_ff   <= {1'b0, ua};
               div_d_ff   <= {1'b0, ua} + {1'b0, ub} + (VW+1)'(1);
               div_cnt_ff <= 5'd0;
               state_ff   <= S_P_DIV;
            end
            S_P_DIV: begin
               div_r_ff   <= div_ge ? (VW+1)'(div_r2 - {1'b0, div_d_ff}) : (VW+1)'(div_r2);
               q_ff       <= {q_ff[30:0], div_ge};
               div_cnt_ff <= div_cnt_ff + 5'd1;
               if (div_cnt_ff == 5'd31) begin
                  state_ff <= S_P_MUL_TI;
               end
            end
            S_P_MUL_TI: begin
               if (wait_ff && mul_done) begin
                  ti_ff    <= pei_pkg::add_sat(item_ff.scalar_a, mul_res);
                  state_ff <= S_P_MUL_TJ;
               end
            end
            S_P_MUL_TJ: begin
               if (wait_ff && mul_done) begin
                  tj_ff    <= pei_pkg::add_sat(item_ff.scalar_b, mul_res);
                  state_ff <= S_P_RD_MASS_B;
               end
            end
            S_P_RD_MASS_B: state_ff <= S_P_MUL_AI;
            S_P_MUL_AI: begin
               if (wait_ff && mul_done) begin
                  ai_ff    <= mul_res;
                  state_ff <= S_P_RD_MASS_A;
               end
            end
            S_P_RD_MASS_A: state_ff <= S_P_MUL_BI;
            S_P_MUL_BI: begin
               if (wait_ff && mul_done) begin
                  bi_ff    <= mul_res;
                  state_ff <= S_P_RD_RATE_A;
               end
            end
            // node i is written back before node j is read, so i == j chains
            S_P_RD_RATE_A: state_ff <= S_P_WR_RATE_A;
            S_P_WR_RATE_A: state_ff <= S_P_RD_RATE_B;
            S_P_RD_RATE_B: state_ff <= S_P_WR_RATE_B;
            S_P_WR_RATE_B: state_ff <= S_IDLE;
            S_R_RD: state_ff <= S_R_MUL;
            S_R_MUL: begin
               if (!wait_ff) begin
                  vsave_ff <= energy_rd_ff;
                  ai_ff    <= rate_rd_ff;
               end else if (mul_done) begin
                  ti_ff    <= pei_pkg::add_sat(vsave_ff, mul_res);
                  state_ff <= S_R_OUT;
               end
            end
            // hold until the output register is free
            S_R_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_ff.out_node    <= item_ff.node_a;
                  rsp_ff.new_energy  <= ti_ff;
                  rsp_ff.energy_rate <= ai_ff;
                  rsp_valid_ff       <= 1'b1;
                  state_ff           <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall   = state_ff != S_IDLE;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // an accepted item always occupies the sequencer on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("sequencer did not leave idle after accepting an item");

   // a multiplier result only arrives while the sequencer waits for one
   a_mul_expected: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> wait_ff && in_mul)
      else $error("multiplier result arrived with no product pending");

   // a response appears only from the read output step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_R_OUT)
      else $error("response raised outside the read output step");

endmodule
